### sv/spm_pkg.sv
// Shared types and constants for the SPI master shift engine.
package spm_pkg;

  // Bit position of the first bit sent and received.
  localparam logic [2:0] TopBit = 3'd7;

  // Action codes carried by each input request.
  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_START = 1'b1
  } spm_action_e;

  // One input request: a tick that may start a byte.
  typedef struct packed {
    spm_action_e action;
    logic [7:0]  tx_byte;
    logic [1:0]  xfer_mode;
    logic        last_of_block;
    logic        miso_level;
  } spm_item_t;

  // One result request: pin levels and completion status after the tick.
  typedef struct packed {
    logic       sclk;
    logic       mosi;
    logic [7:0] rx_byte;
    logic       byte_done;
    logic       block_done;
    logic       busy;
  } spm_result_t;

endpackage

### sv/spi_master_shift_engine.sv
// Top level of the SPI master shift engine: handshakes, config and result register.
//
//  Channel  Direction  Handshake                Payload
//  in       request    in_valid_i/in_stall_o    action, tx_byte, xfer_mode, last_of_block,
//                                               miso_level
//  out      result     out_valid_o/out_stall_i  sclk, mosi, rx_byte, byte_done, block_done,
//                                               busy_res
//  cfg      write      cfg_valid_i/cfg_ready_o  cfg_half_period_extra_i
//
// Each accepted request is one tick; its result is registered and offered on the
// next cycle, so the single result register sustains one request per cycle while unstalled.
// A byte takes the start tick plus 16 half periods of 1 + half_period_extra ticks.
// Reset clears the transfer state and the result valid; SCLK idles low after reset.
// A stalled result holds and blocks new requests only while it is not taken.
module spi_master_shift_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] tx_byte_i,
  input  logic [1:0] xfer_mode_i,
  input  logic       last_of_block_i,
  input  logic       miso_level_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       sclk_o,
  output logic       mosi_o,
  output logic [7:0] rx_byte_o,
  output logic       byte_done_o,
  output logic       block_done_o,
  output logic       busy_res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_half_period_extra_i
);
  import spm_pkg::*;

  logic        accept;
  logic [7:0]  half_extra_q;
  logic        out_valid_q;
  spm_item_t   item;
  spm_result_t result;
  spm_result_t result_q;

  // The result register can load when empty or when it is being taken.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign item.action        = spm_action_e'(action_i);
  assign item.tx_byte       = tx_byte_i;
  assign item.xfer_mode     = xfer_mode_i;
  assign item.last_of_block = last_of_block_i;
  assign item.miso_level    = miso_level_i;

  spm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .half_extra_i (half_extra_q),
    .item_i       (item),
    .result_o     (result)
  );

  // Configuration register, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_extra_q <= '0;
    end else if (cfg_valid_i) begin
      half_extra_q <= cfg_half_period_extra_i;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q <= '0;
    end else if (accept) begin
      result_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sclk_o       = result_q.sclk;
  assign mosi_o       = result_q.mosi;
  assign rx_byte_o    = result_q.rx_byte;
  assign byte_done_o  = result_q.byte_done;
  assign block_done_o = result_q.block_done;
  assign busy_res_o   = result_q.busy;

endmodule

### sv/spm_engine.sv
// Transfer state and per-tick update logic of the SPI shift engine.
module spm_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          half_extra_i,
  input  spm_pkg::spm_item_t  item_i,
  output spm_pkg::spm_result_t result_o
);
  import spm_pkg::*;

  logic       active_q, active_d;
  logic [1:0] mode_q, mode_d;
  logic [7:0] tx_shift_q, tx_shift_d;
  logic [7:0] rx_shift_q, rx_shift_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic       second_half_q, second_half_d;
  logic [7:0] tick_cnt_q, tick_cnt_d;
  logic       last_flag_q, last_flag_d;

  // Next state and result for one tick.
  always_comb begin
    active_d      = active_q;
    mode_d        = mode_q;
    tx_shift_d    = tx_shift_q;
    rx_shift_d    = rx_shift_q;
    bit_idx_d     = bit_idx_q;
    second_half_d = second_half_q;
    tick_cnt_d    = tick_cnt_q;
    last_flag_d   = last_flag_q;
    result_o      = '0;

    if (active_q) begin
      if (tick_cnt_q >= half_extra_i) begin
        tick_cnt_d = '0;
        if (!second_half_q) begin
          // Capture edge: shift MISO in.
          rx_shift_d    = {rx_shift_q[6:0], item_i.miso_level};
          second_half_d = 1'b1;
        end else begin
          second_half_d = 1'b0;
          if (bit_idx_q == '0) begin
            active_d            = 1'b0;
            result_o.byte_done  = 1'b1;
            result_o.block_done = last_flag_q;
            result_o.rx_byte    = rx_shift_q;
          end else begin
            bit_idx_d  = bit_idx_q - 3'd1;
            tx_shift_d = {tx_shift_q[6:0], 1'b0};
          end
        end
      end else begin
        tick_cnt_d = tick_cnt_q + 8'd1;
      end
    end else if (item_i.action == ACT_START) begin
      active_d      = 1'b1;
      mode_d        = item_i.xfer_mode;
      tx_shift_d    = item_i.tx_byte;
      rx_shift_d    = '0;
      bit_idx_d     = TopBit;
      second_half_d = 1'b0;
      tick_cnt_d    = '0;
      last_flag_d   = item_i.last_of_block;
    end

    // SCLK rests at CPOL; while active it follows CPOL ^ CPHA ^ half.
    if (active_d) begin
      result_o.sclk = mode_d[1] ^ mode_d[0] ^ second_half_d;
    end else begin
      result_o.sclk = mode_d[1];
    end
    result_o.mosi = tx_shift_d[TopBit];
    result_o.busy = active_d;
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      mode_q        <= '0;
      tx_shift_q    <= '0;
      rx_shift_q    <= '0;
      bit_idx_q     <= '0;
      second_half_q <= 1'b0;
      tick_cnt_q    <= '0;
      last_flag_q   <= 1'b0;
    end else if (step_i) begin
      active_q      <= active_d;
      mode_q        <= mode_d;
      tx_shift_q    <= tx_shift_d;
      rx_shift_q    <= rx_shift_d;
      bit_idx_q     <= bit_idx_d;
      second_half_q <= second_half_d;
      tick_cnt_q    <= tick_cnt_d;
      last_flag_q   <= last_flag_d;
    end
  end

endmodule
